/* src/fwthc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fwthc_pkg;

    localparam int NUM_POS_REGS    = 5;
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int POS_W           = 8;
    localparam int THR_W           = 16;
    localparam int TIME_W          = 32;
    localparam int BTN_W           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_UP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_DOWN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD  = 3'd5;

    localparam logic [THR_W-1:0] HOLD_THRESHOLD_RST = 16'd500;

    typedef struct packed {
        logic [POS_W-1:0]  key_position;
        logic              pressed;
        logic [TIME_W-1:0] event_time_ms;
        logic              layer_active;
    } t_in_item;

    typedef struct packed {
        logic             handled;
        logic             report_valid;
        logic [BTN_W-1:0] button;
        logic             hold_action;
    } t_out_item;

    typedef struct packed {
        logic             hit;
        logic [BTN_W-1:0] idx;
    } t_match;

endpackage

`default_nettype wire

/* src/five_way_tap_hold_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tap/hold classifier for a five-way navigation switch. Each accepted key
// request produces exactly one result, in order; a new request can be taken
// every cycle while the skid entry is empty. The position compare, the
// held-time subtraction and the threshold compare are combinational, between
// the input handshake and the output register, and a two-entry output buffer
// keeps the input side running for one more request while a result waits.
// Configuration writes are taken every cycle and must only happen while idle.
module five_way_tap_hold_classifier_top
    import fwthc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_MATCH = (NUM_BUTTONS < NUM_POS_REGS) ? NUM_BUTTONS : NUM_POS_REGS;
    localparam int IDX_W     = (NUM_MATCH > 1) ? $clog2(NUM_MATCH) : 1;

    logic [POS_W-1:0]     r_positions [NUM_POS_REGS];
    logic [THR_W-1:0]     r_threshold;
    logic [NUM_MATCH-1:0] r_down_bits;
    logic [NUM_MATCH-1:0] n_down_bits;
    logic [TIME_W-1:0]    r_press_time [NUM_MATCH];

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    t_match               w_match;
    logic [NUM_MATCH-1:0] w_bit;
    logic [TIME_W-1:0]    w_held;
    logic                 w_single;
    logic                 w_in_fire;
    logic                 w_out_fire;
    logic                 w_write_time;
    t_out_item            w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POS_REGS; i++) begin
                r_positions[i] <= POS_W'(i);
            end
            r_threshold <= HOLD_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_POSITION_UP:     r_positions[0] <= i_cfg_data[POS_W-1:0];
                REG_POSITION_DOWN:   r_positions[1] <= i_cfg_data[POS_W-1:0];
                REG_POSITION_LEFT:   r_positions[2] <= i_cfg_data[POS_W-1:0];
                REG_POSITION_RIGHT:  r_positions[3] <= i_cfg_data[POS_W-1:0];
                REG_POSITION_CENTER: r_positions[4] <= i_cfg_data[POS_W-1:0];
                REG_HOLD_THRESHOLD:  r_threshold    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    fwthc_match #(
        .NUM_MATCH (NUM_MATCH)
    ) u_match (
        .i_key_position (i_in_data.key_position),
        .i_positions    (r_positions),
        .o_match        (w_match)
    );

    always_comb begin
        for (int b = 0; b < NUM_MATCH; b++) begin
            w_bit[b] = w_match.hit && (w_match.idx == BTN_W'(b));
        end
    end

    // A press only ever sets a down bit together with its time, so the time
    // read on a release with the bit set has always been written.
    assign w_held   = i_in_data.event_time_ms - r_press_time[w_match.idx[IDX_W-1:0]];
    assign w_single = ((r_down_bits & (r_down_bits - 1'b1)) == '0);

    always_comb begin
        w_result     = '0;
        n_down_bits  = r_down_bits;
        w_write_time = 1'b0;
        if (w_match.hit) begin
            w_result.button = w_match.idx;
            if (!i_in_data.layer_active) begin
                n_down_bits = r_down_bits & ~w_bit;
            end else if (i_in_data.pressed) begin
                w_result.handled = 1'b1;
                n_down_bits      = r_down_bits | w_bit;
                w_write_time     = 1'b1;
            end else begin
                w_result.handled = 1'b1;
                n_down_bits      = r_down_bits & ~w_bit;
                if (((r_down_bits & w_bit) != '0) && w_single) begin
                    w_result.report_valid = 1'b1;
                    w_result.hold_action  = (w_held >= TIME_W'(r_threshold));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_bits <= '0;
        end else if (w_in_fire) begin
            r_down_bits <= n_down_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_write_time) begin
            r_press_time[w_match.idx[IDX_W-1:0]] <= i_in_data.event_time_ms;
        end
    end

    // Output register plus one skid entry; input ready drops only when both hold data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a valid output");

    a_report_is_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_valid) |-> o_out_data.handled)
        else $error("report produced for an event that was passed on");

    a_report_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_valid) |-> (o_out_data.button < BTN_W'(NUM_MATCH)))
        else $error("report names a button outside the configured set");

    a_press_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_match.hit && i_in_data.layer_active && i_in_data.pressed)
        |=> ((r_down_bits & $past(w_bit)) == $past(w_bit)))
        else $error("press did not set the down bit");

    a_hold_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hold_action) |-> o_out_data.report_valid)
        else $error("hold flagged without a report");

endmodule

`default_nettype wire

/* src/fwthc_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwthc_match
    import fwthc_pkg::*;
#(
    parameter int NUM_MATCH = NUM_POS_REGS
) (
    input  wire logic [POS_W-1:0] i_key_position,
    input  wire logic [POS_W-1:0] i_positions [NUM_POS_REGS],
    output t_match                o_match
);

    // Scan from the highest button down so that the lowest matching one wins.
    always_comb begin
        o_match = '0;
        for (int b = NUM_MATCH - 1; b >= 0; b--) begin
            if (i_positions[b] == i_key_position) begin
                o_match.hit = 1'b1;
                o_match.idx = BTN_W'(b);
            end
        end
    end

endmodule

`default_nettype wire
